FILE: rtl/nsf_pkg.sv
`timescale 1ns / 1ps

package nsf_pkg;

    localparam int MAX_PATTERN_DEF = 8;
    localparam int MAX_LEN_DEF     = 65536;
    localparam int POS_W           = 16;
    localparam int CFG_IDX_W       = 8;
    localparam int CFG_DATA_W      = 64;
    localparam int PLEN_REG_W      = 4;
    localparam int COUNT_W         = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OCCURRENCE    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CASE   = 8'd3;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last;
    } t_in;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_out;

    // one classified byte handed from the front to the back
    typedef struct packed {
        logic             cmp;
        logic             active;
        logic             last;
        logic [POS_W-1:0] pos;
    } t_rec;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic ign);
        logic [7:0] r;
        r = c;
        if (ign && c >= 8'h61 && c <= 8'h7a) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

FILE: rtl/nth_substring_finder.sv
`timescale 1ns / 1ps

// Finds the start index of the nth non-overlapping occurrence of a 1 to 8 byte
// pattern in a byte string fed one byte per request, with a last marker closing
// each string. One result comes per string: found with the start index at the
// byte completing the nth match, or not found at the last byte. The block
// takes one byte per clock while its queues have room. The front's parallel
// window compare works in the accepting cycle; its record passes through the
// middle queue to the back's match counter update, whose result goes through
// the result queue to the output. Small queues between the front, the back
// and the output absorb a stall on either side until they fill. The user must
// write configuration only while no string is in flight; nothing enforces it.
module nth_substring_finder #(
    parameter int MAX_PATTERN = nsf_pkg::MAX_PATTERN_DEF,
    parameter int MAX_LEN     = nsf_pkg::MAX_LEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  nsf_pkg::t_in                    i_data,
    output logic                            empty,
    input  logic                            pop,
    output nsf_pkg::t_out                   o_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [nsf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [nsf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import nsf_pkg::*;

    localparam int PLEN_W = $clog2(MAX_PATTERN + 1);

    logic [CFG_DATA_W-1:0] r_pattern;
    logic [PLEN_REG_W-1:0] r_plen;
    logic [COUNT_W-1:0]    r_occ;
    logic                  r_ign;
    logic [PLEN_W-1:0]     len;

    logic accept;
    t_rec front_rec, back_rec;
    logic mid_full, mid_empty, mid_pop;
    logic res_full, res_push;
    t_out res;

    assign o_cfg_ready = 1'b1;
    assign len    = (int'(r_plen) > MAX_PATTERN) ? PLEN_W'(MAX_PATTERN) : PLEN_W'(r_plen);
    assign full   = mid_full;
    assign accept = push && !mid_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_plen    <= PLEN_REG_W'(1);
            r_occ     <= COUNT_W'(1);
            r_ign     <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PATTERN_BYTES: r_pattern <= i_cfg_data;
                CFG_PATTERN_LEN:   r_plen    <= i_cfg_data[PLEN_REG_W-1:0];
                CFG_OCCURRENCE:    r_occ     <= i_cfg_data[COUNT_W-1:0];
                CFG_IGNORE_CASE:   r_ign     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    nsf_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_LEN     (MAX_LEN),
        .PLEN_W      (PLEN_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (i_data),
        .i_pattern     (r_pattern),
        .i_len         (len),
        .i_ignore_case (r_ign),
        .o_rec         (front_rec)
    );

    nsf_fifo #(
        .WIDTH ($bits(t_rec)),
        .DEPTH (2)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_rec),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (back_rec),
        .o_empty (mid_empty)
    );

    nsf_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .PLEN_W      (PLEN_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rec        (back_rec),
        .i_rec_empty  (mid_empty),
        .o_rec_pop    (mid_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (res),
        .i_len        (len),
        .i_occurrence (r_occ)
    );

    nsf_fifo #(
        .WIDTH ($bits(t_out)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_data),
        .o_empty (empty)
    );

endmodule

FILE: rtl/nsf_fifo.sv
`timescale 1ns / 1ps

module nsf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: rtl/nsf_front.sv
`timescale 1ns / 1ps

module nsf_front #(
    parameter int MAX_PATTERN = nsf_pkg::MAX_PATTERN_DEF,
    parameter int MAX_LEN     = nsf_pkg::MAX_LEN_DEF,
    parameter int PLEN_W      = $clog2(MAX_PATTERN + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  nsf_pkg::t_in                    i_item,
    input  logic [nsf_pkg::CFG_DATA_W-1:0]  i_pattern,
    input  logic [PLEN_W-1:0]               i_len,
    input  logic                            i_ignore_case,
    output nsf_pkg::t_rec                   o_rec
);
    import nsf_pkg::*;

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int BI_W  = $clog2(MAX_LEN + 1);

    logic [7:0]      r_win [MAX_PATTERN];
    logic [7:0]      n_win [MAX_PATTERN];
    logic [BI_W-1:0] r_idx, n_idx;
    logic            active;
    logic            cmp;
    logic [BI_W-1:0] start;

    assign active = (r_idx < BI_W'(MAX_LEN));

    // window as it stands once this byte is shifted in
    always_comb begin
        n_win[0] = i_item.byte_value;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            n_win[j] = r_win[j-1];
        end
    end

    // pattern byte k lines up with the byte len-1-k places back
    always_comb begin
        logic [IDX_W-1:0] sel;
        cmp = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            sel = IDX_W'(int'(i_len) - 1 - k);
            if (k < int'(i_len)) begin
                if (fold(i_pattern[8*k +: 8], i_ignore_case) !=
                    fold(n_win[sel], i_ignore_case)) begin
                    cmp = 1'b0;
                end
            end
        end
    end

    assign start = r_idx + BI_W'(1) - BI_W'(i_len);

    always_comb begin
        o_rec.cmp    = cmp;
        o_rec.active = active;
        o_rec.last   = i_item.last;
        o_rec.pos    = POS_W'(start);
    end

    always_comb begin
        n_idx = r_idx;
        if (i_accept) begin
            if (i_item.last) begin
                n_idx = '0;
            end else if (active) begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            for (int j = 0; j < MAX_PATTERN; j++) begin
                r_win[j] <= '0;
            end
        end else begin
            r_idx <= n_idx;
            if (i_accept) begin
                for (int j = 0; j < MAX_PATTERN; j++) begin
                    if (i_item.last) begin
                        r_win[j] <= '0;
                    end else if (active) begin
                        r_win[j] <= n_win[j];
                    end
                end
            end
        end
    end

endmodule

FILE: rtl/nsf_back.sv
`timescale 1ns / 1ps

module nsf_back #(
    parameter int MAX_PATTERN = nsf_pkg::MAX_PATTERN_DEF,
    parameter int PLEN_W      = $clog2(MAX_PATTERN + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  nsf_pkg::t_rec                i_rec,
    input  logic                         i_rec_empty,
    output logic                         o_rec_pop,
    input  logic                         i_res_full,
    output logic                         o_res_push,
    output nsf_pkg::t_out                o_res,
    input  logic [PLEN_W-1:0]            i_len,
    input  logic [nsf_pkg::COUNT_W-1:0]  i_occurrence
);
    import nsf_pkg::*;

    logic [PLEN_W-1:0]  r_fill, n_fill;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_reported, n_reported;
    logic               take;
    logic               hit;

    assign take      = !i_rec_empty && !i_res_full;
    assign o_rec_pop = take;

    always_comb begin
        logic [PLEN_W-1:0] fill_inc;
        n_fill     = r_fill;
        n_count    = r_count;
        n_reported = r_reported;
        hit        = 1'b0;
        o_res      = '0;
        fill_inc   = (r_fill < PLEN_W'(MAX_PATTERN)) ? r_fill + 1'b1 : r_fill;
        if (!r_reported && i_rec.active) begin
            n_fill = fill_inc;
            if (i_len != '0 && i_occurrence != '0 && fill_inc >= i_len && i_rec.cmp) begin
                n_fill = '0;
                if (r_count != '1) begin
                    n_count = r_count + 1'b1;
                end
                if (n_count == i_occurrence) begin
                    hit            = 1'b1;
                    n_reported     = 1'b1;
                    o_res.found    = 1'b1;
                    o_res.position = i_rec.pos;
                end
            end
        end
        if (i_rec.last) begin
            // string ends without a report: not-found result
            if (!n_reported) begin
                hit = 1'b1;
            end
            n_fill     = '0;
            n_count    = '0;
            n_reported = 1'b0;
        end
    end

    assign o_res_push = take && hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_count    <= '0;
            r_reported <= 1'b0;
        end else if (take) begin
            r_fill     <= n_fill;
            r_count    <= n_count;
            r_reported <= n_reported;
        end
    end

endmodule
